// ===== rtl/triangle_midpoint_subdivide_macros.svh =====
// assertion macros shared by the triangle subdivider rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDE_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tms_pkg.sv =====
// shared constants, child codes and width helpers for the triangle subdivider
// no dependencies
package tms_pkg;

  // child triangle codes, in output order
  localparam logic [1:0] CHILD_TOP = 2'd0;
  localparam logic [1:0] CHILD_BR  = 2'd1;
  localparam logic [1:0] CHILD_BL  = 2'd2;
  localparam logic [1:0] CHILD_MID = 2'd3;

  // unit component holds at most 2^30, so 31 quotient bits
  localparam int Q_BITS  = 31;
  localparam int U_SHIFT = 36;
  localparam int R_SHIFT = 30;

  // width of the pre-shifted magnitude t
  function automatic int tri_t_width(input int cw);
    return ((cw > 24) ? 24 : cw) + 1;
  endfunction

  // width of floor(sqrt(S * 1024))
  function automatic int sqrt_width(input int cw);
    int tw;
    tw = tri_t_width(cw);
    return (2 * tw + 2 + 10 + 1) / 2;
  endfunction

  // cycles from input register to registered midpoint
  function automatic int lane_latency(input int cw);
    return sqrt_width(cw) + Q_BITS + 6;
  endfunction

endpackage

// ===== rtl/tms_lane.sv =====
// one midpoint lane: edge sum, optional projection onto the sphere
// uses tms_pkg; pipelined square root and division, one bit per stage
module tms_lane #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [2:0][COORD_WIDTH-1:0]          p,
  input  logic [2:0][COORD_WIDTH-1:0]          q,
  input  logic [COORD_WIDTH-2:0]               radius,
  output logic [2:0][COORD_WIDTH-1:0]          mid
);
  import tms_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DSH  = (CW > 24) ? CW - 24 : 0;
  localparam int TW   = tri_t_width(CW);
  localparam int SW   = 2 * TW + 2;
  localparam int LW   = sqrt_width(CW);
  localparam int NW   = 2 * LW;
  localparam int RMW  = LW + 3;
  localparam int DW   = LW + 1;
  localparam int QW   = Q_BITS;
  localparam int NUMW = TW + U_SHIFT + 1;
  localparam int XW   = (NUMW > DW + QW) ? NUMW : DW + QW;
  localparam int PW   = QW + CW - 1;
  localparam int RRW  = PW + 1 - R_SHIFT;
  localparam logic [RRW-1:0] RMAX = RRW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [CW-1:0]  CMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0]  CMIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [PW:0]    RND  = (PW + 1)'(1) << (R_SHIFT - 1);

  typedef struct packed {
    logic [2:0][TW-1:0] t;
    logic [2:0]         neg;
    logic [2:0][CW-1:0] half;
    logic               zero;
  } com_t;

  // stage 1: sums, magnitudes, floor halves
  com_t c1_r, c1_nxt;
  always_comb begin
    logic signed [CW:0] s;
    logic [CW:0] mag;
    c1_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      s = $signed({p[k][CW-1], p[k]}) + $signed({q[k][CW-1], q[k]});
      mag = s[CW] ? (CW + 1)'(-s) : (CW + 1)'(s);
      c1_nxt.neg[k]  = s[CW];
      c1_nxt.t[k]    = TW'(mag >> DSH);
      c1_nxt.half[k] = s[CW:1];
    end
  end

  // stage 2: squares
  com_t c2_r;
  logic [2:0][2*TW-1:0] sq_r;
  // stage 3: scaled sum of squares
  com_t c3_r, c3_nxt;
  logic [NW-1:0] n_r;
  logic [SW-1:0] ssum;

  assign ssum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_comb begin
    c3_nxt      = c2_r;
    c3_nxt.zero = (ssum == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= c1_nxt;
      c2_r <= c1_r;
      for (int k = 0; k < 3; k++) sq_r[k] <= c1_r.t[k] * c1_r.t[k];
      c3_r <= c3_nxt;
      n_r  <= NW'(ssum) << 10;
    end
  end

  // square root, one result bit per stage
  logic [LW-1:0]  rt_r [LW];
  logic [RMW-1:0] rm_r [LW];
  logic [NW-1:0]  nn_r [LW];
  com_t           sc_r [LW];

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    logic [LW-1:0]  root_in;
    logic [RMW-1:0] rem_in;
    logic [NW-1:0]  n_in;
    com_t           c_in;
    logic [RMW-1:0] cat, trial;
    logic           ge;
    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign n_in    = n_r;
      assign c_in    = c3_r;
    end else begin : g_next
      assign root_in = rt_r[k-1];
      assign rem_in  = rm_r[k-1];
      assign n_in    = nn_r[k-1];
      assign c_in    = sc_r[k-1];
    end
    assign cat   = {rem_in[RMW-3:0], n_in[NW-1-2*k -: 2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = (cat >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[k] <= {root_in[LW-2:0], ge};
        rm_r[k] <= ge ? cat - trial : cat;
        nn_r[k] <= n_in;
        sc_r[k] <= c_in;
      end
    end
  end

  // divisor 2L and rounded numerators t * 2^36 + L
  com_t c4_r;
  logic [DW-1:0]        dv_r;
  logic [2:0][XW-1:0]   qn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c4_r <= sc_r[LW-1];
      dv_r <= {rt_r[LW-1], 1'b0};
      for (int k = 0; k < 3; k++)
        qn_r[k] <= (XW'(sc_r[LW-1].t[k]) << U_SHIFT) + XW'(rt_r[LW-1]);
    end
  end

  // restoring division, one quotient bit per stage, three axes side by side
  logic [2:0][XW-1:0] dr_r [QW];
  logic [2:0][QW-1:0] dq_r [QW];
  logic [DW-1:0]      dd_r [QW];
  com_t               dc_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [2:0][XW-1:0] rem_in;
    logic [2:0][QW-1:0] q_in;
    logic [DW-1:0]      d_in;
    com_t               c_in;
    logic [XW-1:0]      dsh;
    if (i == 0) begin : g_first
      assign rem_in = qn_r;
      assign q_in   = '0;
      assign d_in   = dv_r;
      assign c_in   = c4_r;
    end else begin : g_next
      assign rem_in = dr_r[i-1];
      assign q_in   = dq_r[i-1];
      assign d_in   = dd_r[i-1];
      assign c_in   = dc_r[i-1];
    end
    assign dsh = XW'(d_in) << (QW - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          dr_r[i][k] <= (rem_in[k] >= dsh) ? rem_in[k] - dsh : rem_in[k];
          dq_r[i][k] <= {q_in[k][QW-2:0], (rem_in[k] >= dsh)};
        end
        dd_r[i] <= d_in;
        dc_r[i] <= c_in;
      end
    end
  end

  // scale by radius
  com_t c5_r;
  logic [2:0][PW-1:0] pr_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c5_r <= dc_r[QW-1];
      for (int k = 0; k < 3; k++) pr_r[k] <= PW'(dq_r[QW-1][k]) * PW'(radius);
    end
  end

  // round, saturate, pick the result
  logic [2:0][CW-1:0] mid_nxt, mid_r;
  always_comb begin
    logic [PW:0]    sum;
    logic [RRW-1:0] r;
    logic [CW-1:0]  pv;
    for (int k = 0; k < 3; k++) begin
      sum = (PW + 1)'(pr_r[k]) + RND;
      r   = sum[PW:R_SHIFT];
      if (!c5_r.neg[k]) begin
        pv = (r > RMAX) ? CMAX : r[CW-1:0];
      end else begin
        pv = (r > RMAX + RRW'(1)) ? CMIN : CW'(~r + RRW'(1));
      end
      if (radius == '0) begin
        mid_nxt[k] = c5_r.half[k];
      end else if (c5_r.zero) begin
        mid_nxt[k] = '0;
      end else begin
        mid_nxt[k] = pv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) mid_r <= mid_nxt;
  end

  assign mid = mid_r;

endmodule

// ===== rtl/tms_emit.sv =====
// merging stage: holds one parent with its midpoints and sends four children
// uses tms_pkg for the child codes
module tms_emit #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tri_valid,
  output logic                        can_load,
  input  logic [2:0][COORD_WIDTH-1:0] a,
  input  logic [2:0][COORD_WIDTH-1:0] b,
  input  logic [2:0][COORD_WIDTH-1:0] c,
  input  logic [2:0][COORD_WIDTH-1:0] m0,
  input  logic [2:0][COORD_WIDTH-1:0] m1,
  input  logic [2:0][COORD_WIDTH-1:0] m2,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0][COORD_WIDTH-1:0] cp,
  output logic [2:0][COORD_WIDTH-1:0] cq,
  output logic [2:0][COORD_WIDTH-1:0] cr,
  output logic [1:0]                  idx,
  output logic                        last
);
  import tms_pkg::*;

  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0][COORD_WIDTH-1:0] a_r, b_r, c_r, m0_r, m1_r, m2_r;
  logic take, load;

  assign last     = (idx_r == CHILD_MID);
  assign take     = busy_r && out_ready;
  assign can_load = !busy_r || (take && last);
  assign load     = tri_valid && can_load;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = CHILD_TOP;
    end else if (take) begin
      busy_nxt = !last;
      idx_nxt  = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= CHILD_TOP;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r  <= a;
      b_r  <= b;
      c_r  <= c;
      m0_r <= m0;
      m1_r <= m1;
      m2_r <= m2;
    end
  end

  always_comb begin
    case (idx_r)
      CHILD_TOP: begin cp = a_r;  cq = m0_r; cr = m2_r; end
      CHILD_BR:  begin cp = m0_r; cq = b_r;  cr = m1_r; end
      CHILD_BL:  begin cp = m2_r; cq = m1_r; cr = c_r;  end
      CHILD_MID: begin cp = m1_r; cq = m2_r; cr = m0_r; end
      default:   begin cp = a_r;  cq = m0_r; cr = m2_r; end
    endcase
  end

  assign out_valid = busy_r;
  assign idx       = idx_r;

endmodule

// ===== rtl/triangle_midpoint_subdivide.sv =====
// Midpoint subdivider: takes one triangle per input request and returns its four
// children (top, bottom-right, bottom-left, middle; tlast on the middle one).
// Three lanes form the edge midpoints in parallel and, with a nonzero radius,
// project them onto the sphere through a pipelined square root and divider.
// The output stage sends four child requests per parent and takes the next
// parent as the middle child is accepted; the lanes stall while a finished
// triangle waits for the output stage.
// Depends on tms_pkg, tms_lane, tms_emit and the macros header.
`include "triangle_midpoint_subdivide_macros.svh"

module triangle_midpoint_subdivide #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, zero pad
  output logic [((9*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // child_index
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  input  logic                                   cfg_wr_en,
  input  logic [COORD_WIDTH-2:0]                 cfg_wr_data
);
  import tms_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int RW  = CW - 1;
  localparam int DTW = ((9 * CW + 7) / 8) * 8;
  localparam int LAT = lane_latency(CW);
  localparam logic [RW-1:0] RAD_RST = RW'(1) << FRAC_BITS;

  logic [RW-1:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RAD_RST;
    else if (cfg_wr_en) radius_r <= cfg_wr_data;
  end

  logic [2:0][CW-1:0] in_a, in_b, in_c;
  assign in_a = in_tdata[3*CW-1:0];
  assign in_b = in_tdata[6*CW-1:3*CW];
  assign in_c = in_tdata[9*CW-1:6*CW];

  logic adv, can_load;
  logic [LAT-1:0] vld_r;
  logic [2:0][2:0][CW-1:0] vtx_r [LAT];

  assign adv       = !vld_r[LAT-1] || can_load;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  // corners travel alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      vtx_r[0] <= {in_c, in_b, in_a};
      for (int i = 1; i < LAT; i++) vtx_r[i] <= vtx_r[i-1];
    end
  end

  logic [2:0][CW-1:0] m0, m1, m2;

  tms_lane #(.COORD_WIDTH(CW)) u_lane_ab (
    .clk(clk), .en(adv), .p(in_a), .q(in_b), .radius(radius_r), .mid(m0)
  );
  tms_lane #(.COORD_WIDTH(CW)) u_lane_bc (
    .clk(clk), .en(adv), .p(in_b), .q(in_c), .radius(radius_r), .mid(m1)
  );
  tms_lane #(.COORD_WIDTH(CW)) u_lane_ca (
    .clk(clk), .en(adv), .p(in_c), .q(in_a), .radius(radius_r), .mid(m2)
  );

  logic [2:0][CW-1:0] cp, cq, cr;

  tms_emit #(.COORD_WIDTH(CW)) u_emit (
    .clk(clk), .rst_n(rst_n),
    .tri_valid(vld_r[LAT-1]), .can_load(can_load),
    .a(vtx_r[LAT-1][0]), .b(vtx_r[LAT-1][1]), .c(vtx_r[LAT-1][2]),
    .m0(m0), .m1(m1), .m2(m2),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .cp(cp), .cq(cq), .cr(cr), .idx(out_tuser), .last(out_tlast)
  );

  assign out_tdata = DTW'({cr, cq, cp});

  `TMS_ASSERT_SAME(a_last_on_mid, out_tvalid, out_tlast == (out_tuser == CHILD_MID))
  `TMS_ASSERT_NEXT(a_run_cont, out_tvalid && out_tready && !out_tlast,
                   out_tvalid && (out_tuser == $past(out_tuser) + 2'd1))
  `TMS_ASSERT_NEXT(a_new_top, out_tvalid && out_tready && out_tlast,
                   !out_tvalid || (out_tuser == CHILD_TOP))

endmodule
